// ===== design/bounded_integer_set_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// Bounded integer set table: assertion macros
// Shared macros for the concurrent checks on the set table's ports.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INTEGER_SET_TABLE_CORE_DEFINES_SVH
`define BOUNDED_INTEGER_SET_TABLE_CORE_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define BIST_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define BIST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded integer set table: package
// Request and response types, action and status codes, and the control
// bundle that the controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package bist_pkg;

    localparam int ELEM_W      = 32;
    localparam int CFG_W       = 7;
    localparam int COUNT_OUT_W = 7;
    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

    // Action codes carried in a request.
    typedef enum logic [2:0] {
        ACT_INSERT    = 3'd0,
        ACT_REMOVE    = 3'd1,
        ACT_MEMBER    = 3'd2,
        ACT_TAKE_LAST = 3'd3,
        ACT_CLEAR     = 3'd4,
        ACT_ITER_INIT = 3'd5,
        ACT_ITER_NEXT = 3'd6
    } bist_action_t;

    // Status codes carried in a response.
    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_PRESENT = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_NONE    = 2'd3
    } bist_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } bist_state_t;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [ELEM_W-1:0] element;
    } bist_req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [ELEM_W-1:0] value;
        logic [COUNT_OUT_W-1:0]   count;
    } bist_rsp_t;

    // Broadcast controls for the cell row.
    typedef struct packed {
        logic look;      // capture the select flag this cycle
        logic by_value;  // select on a stored value match, else on the index
        logic write;     // load the key into the cell at the count
        logic shift;     // cells at or above the position take their neighbour
    } bist_cell_ctrl_t;

endpackage

// ===== design/bist_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded integer set table: storage cell
// Holds one entry of the set. Compares itself against the broadcast key or
// index, and takes its right-hand neighbour's entry when a removal closes
// the gap.
// ----------------------------------------------------------------------------
module bist_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bist_pkg::bist_cell_ctrl_t       ctrl,
    input  logic [bist_pkg::ELEM_W-1:0]     key,
    input  logic [CNT_W-1:0]                sel_idx,
    input  logic [CNT_W-1:0]                count,
    input  logic [CNT_W-1:0]                pos,
    input  logic [bist_pkg::ELEM_W-1:0]     right_data,
    output logic [bist_pkg::ELEM_W-1:0]     data,
    output logic                            sel
);
    import bist_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [ELEM_W-1:0] data_reg;
    logic [ELEM_W-1:0] data_next;
    logic              sel_reg;
    logic              sel_next;

    // Select flag: a live entry equal to the key, or this cell's index.
    always_comb
    begin
        sel_next = sel_reg;
        if (ctrl.look)
        begin
            if (ctrl.by_value)
                sel_next = (MY_IDX < count) && (data_reg == key);
            else
                sel_next = (MY_IDX == sel_idx);
        end
    end

    // Entry update: append at the count, or move down on a removal.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.write && (MY_IDX == count))
            data_next = key;
        else if (ctrl.shift && (MY_IDX >= pos))
            data_next = right_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

    // The entry itself is not reset; it is only read once written.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign sel  = sel_reg;

endmodule

// ===== design/bounded_integer_set_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded integer set table: top level
// Set of up to CAPACITY signed 32-bit integers kept in insertion order.
// ----------------------------------------------------------------------------
// Usage
//   req (valid/ready) carries one request: an action code and an element.
//   rsp (valid/ready) returns one response per request: status, value and
//   the element count after the action.
//   cfg (valid/ready) writes the size limit; it is always ready and must
//   only be written while no request is outstanding.
// Timing
//   A request is accepted while the row of cells compares all entries
//   against it; the next cycle encodes the one selected cell and commits
//   the action into the response register, once that register is free. A
//   new request is taken only after the previous one has committed; the
//   rate is set by the registered match flag in each cell.
// Reset
//   Count and iterator clear, the limit returns to 64, no response pending.
//   Entry contents are not cleared, so there is no clearing pass.
// Stalls
//   A held response keeps its value; one further request can be taken and
//   then waits in its commit cycle until the response register frees.
// ----------------------------------------------------------------------------
module bounded_integer_set_table_core #(
    parameter int CAPACITY = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  bist_pkg::bist_req_t         req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output bist_pkg::bist_rsp_t         rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bist_pkg::CFG_W-1:0]  cfg_data
);
    import bist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [LIM_W-1:0] CAP_LIM = LIM_W'(CAPACITY);

    bist_state_t       state_reg;
    bist_state_t       state_next;
    bist_req_t         req_reg;
    bist_req_t         req_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  iter_reg;
    logic [CNT_W-1:0]  iter_next;
    logic [CFG_W-1:0]  size_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    bist_rsp_t         rsp_reg;
    bist_rsp_t         rsp_next;

    bist_cell_ctrl_t   cell_ctrl;
    logic [ELEM_W-1:0] cell_key;
    logic [CNT_W-1:0]  sel_idx;
    logic [ELEM_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0] cell_sel;

    logic [CAPACITY-1:0] data_col [ELEM_W];
    logic [CAPACITY-1:0] pos_col  [IDX_W];
    logic [ELEM_W-1:0] sel_data;
    logic [IDX_W-1:0]  hit_pos;
    logic [CNT_W-1:0]  pos;
    logic              any_hit;
    logic              is_full;
    logic              iter_ok;
    logic [1:0]        rsp_status;
    logic [ELEM_W-1:0] rsp_value;

    // Row of storage cells; each takes its right-hand neighbour on a shift.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        localparam int NEXT = (g == CAPACITY - 1) ? g : g + 1;

        bist_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .key        (cell_key),
            .sel_idx    (sel_idx),
            .count      (count_reg),
            .pos        (pos),
            .right_data (cell_data[NEXT]),
            .data       (cell_data[g]),
            .sel        (cell_sel[g])
        );
    end

    // At most one cell is selected: OR trees give its data and its index.
    always_comb
    begin
        for (int b = 0; b < ELEM_W; b++)
        begin
            for (int i = 0; i < CAPACITY; i++)
                data_col[b][i] = cell_sel[i] & cell_data[i][b];
            sel_data[b] = |data_col[b];
        end
        for (int b = 0; b < IDX_W; b++)
        begin
            for (int i = 0; i < CAPACITY; i++)
                pos_col[b][i] = cell_sel[i] && (((i >> b) & 1) != 0);
            hit_pos[b] = |pos_col[b];
        end
    end

    assign any_hit = |cell_sel;
    assign pos     = CNT_W'(hit_pos);
    assign is_full = (LIM_W'(count_reg) >= LIM_W'(size_reg)) ||
                     (LIM_W'(count_reg) >= CAP_LIM);
    assign iter_ok = (iter_reg < count_reg);

    // Controller: accept and compare, then commit into the response register.
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        iter_next      = iter_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cell_ctrl      = '0;
        cell_key       = req_reg.element;
        sel_idx        = iter_reg;
        rsp_status     = STAT_NONE;
        rsp_value      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                cell_key = req.element;
                if (req.action == ACT_TAKE_LAST)
                    sel_idx = count_reg - CNT_W'(1);
                if (req_valid)
                begin
                    req_next           = req;
                    cell_ctrl.look     = 1'b1;
                    cell_ctrl.by_value = (req.action == ACT_INSERT) ||
                                         (req.action == ACT_REMOVE) ||
                                         (req.action == ACT_MEMBER);
                    state_next         = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    case (req_reg.action)
                        ACT_INSERT:
                        begin
                            if (is_full)
                                rsp_status = STAT_FULL;
                            else if (any_hit)
                                rsp_status = STAT_PRESENT;
                            else
                            begin
                                cell_ctrl.write = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                rsp_status      = STAT_DONE;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (any_hit)
                            begin
                                cell_ctrl.shift = 1'b1;
                                count_next      = count_reg - CNT_W'(1);
                                rsp_status      = STAT_DONE;
                            end
                        end
                        ACT_MEMBER:
                        begin
                            if (any_hit)
                                rsp_status = STAT_DONE;
                        end
                        ACT_TAKE_LAST:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CNT_W'(1);
                                rsp_value  = sel_data;
                                rsp_status = STAT_DONE;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                            iter_next  = '0;
                            rsp_status = STAT_DONE;
                        end
                        ACT_ITER_INIT:
                        begin
                            iter_next  = '0;
                            rsp_status = STAT_DONE;
                        end
                        ACT_ITER_NEXT:
                        begin
                            if (iter_ok)
                            begin
                                iter_next  = iter_reg + CNT_W'(1);
                                rsp_value  = sel_data;
                                rsp_status = STAT_DONE;
                            end
                        end
                        default:
                        begin
                            rsp_status = STAT_NONE;
                        end
                    endcase
                    rsp_next.status = rsp_status;
                    rsp_next.value  = rsp_value;
                    rsp_next.count  = COUNT_OUT_W'(count_next);
                    rsp_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            iter_reg      <= '0;
            size_reg      <= SIZE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            iter_reg      <= iter_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid)
                size_reg <= cfg_data;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== design/bist_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded integer set table: port checker
// Concurrent checks on the top level's channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_integer_set_table_core_defines.svh"

module bist_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input bist_pkg::bist_rsp_t rsp
);
    import bist_pkg::*;

    // A stalled response holds its payload.
    `BIST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")

    // After a request is taken the block is busy for its commit cycle.
    `BIST_ASSERT_NEXT(a_req_busy, req_valid && req_ready, !req_ready, "request taken on consecutive cycles")

    // Only a completed take or iterator read carries a value.
    `BIST_ASSERT_SAME(a_value_zero, rsp_valid && (rsp.status != STAT_DONE), rsp.value == '0, "value set without done status")

    // A new response follows a busy cycle.
    `BIST_ASSERT_SAME(a_rsp_after_busy, $rose(rsp_valid), !$past(req_ready), "response appeared without a commit cycle")

endmodule

bind bounded_integer_set_table_core bist_checker u_bist_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded integer set table: testbench
// Drives a scripted opening sequence and then weighted random requests into
// the set table, mirrors every accepted request in a behavioural shadow of
// the set and compares each response field by field, under changing size
// limits and with random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb;
    import bist_pkg::*;

    localparam int CAPACITY        = 64;
    localparam int ITEMS_PER_LIMIT = 75;
    localparam int PLAN_LEN        = 12;
    localparam int DRAIN_CYCLES    = 4;
    localparam int LONG_HOLD       = 300;
    localparam int CYCLE_LIMIT     = 400000;
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    // One step of the opening script: either a limit write or a request.
    typedef struct {
        bit                is_cfg;
        logic [CFG_W-1:0]  cfg_value;
        bist_req_t         item;
        bit                typed;
        bist_rsp_t         want;
    } script_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    bist_req_t         req = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    bist_rsp_t         rsp;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;

    // Shadow copy of the set and its size limit.
    logic [ELEM_W-1:0] shadow_store [CAPACITY];
    int                shadow_count = 0;
    int                shadow_iter_pos = 0;
    logic [CFG_W-1:0]  shadow_size_limit = SIZE_RESET;

    bist_rsp_t         pending_responses [$];
    int                error_count = 0;
    int                checked_count = 0;
    int                sent_count = 0;
    int                cycle_count = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                long_hold_cycles = 0;

    bounded_integer_set_table_core #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d responses outstanding.",
                     cycle_count, pending_responses.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Applies one request to the shadow set and returns the response it causes.
    function automatic bist_rsp_t predict_set_action(input bist_req_t item);
        bist_rsp_t res;
        int        lim;
        int        slot;
        int        i;
        res.status = STAT_NONE;
        res.value  = '0;
        lim  = (shadow_size_limit < CAPACITY) ? int'(shadow_size_limit) : CAPACITY;
        slot = shadow_count;
        for (i = 0; i < shadow_count; i++)
            if (shadow_store[i] == item.element && slot == shadow_count)
                slot = i;
        case (item.action)
            ACT_INSERT:
            begin
                // The full test takes precedence over the repeat test.
                if (shadow_count >= lim)
                    res.status = STAT_FULL;
                else if (slot < shadow_count)
                    res.status = STAT_PRESENT;
                else
                begin
                    shadow_store[shadow_count] = item.element;
                    shadow_count++;
                    res.status = STAT_DONE;
                end
            end
            ACT_REMOVE:
            begin
                // Later entries move down to close the gap.
                if (slot < shadow_count)
                begin
                    shadow_count--;
                    for (i = slot; i < shadow_count; i++)
                        shadow_store[i] = shadow_store[i + 1];
                    res.status = STAT_DONE;
                end
            end
            ACT_MEMBER:
                res.status = (slot < shadow_count) ? STAT_DONE : STAT_NONE;
            ACT_TAKE_LAST:
            begin
                if (shadow_count > 0)
                begin
                    shadow_count--;
                    res.value  = shadow_store[shadow_count];
                    res.status = STAT_DONE;
                end
            end
            ACT_CLEAR:
            begin
                shadow_count    = 0;
                shadow_iter_pos = 0;
                res.status      = STAT_DONE;
            end
            ACT_ITER_INIT:
            begin
                shadow_iter_pos = 0;
                res.status      = STAT_DONE;
            end
            ACT_ITER_NEXT:
            begin
                if (shadow_iter_pos < shadow_count)
                begin
                    res.value  = shadow_store[shadow_iter_pos];
                    shadow_iter_pos++;
                    res.status = STAT_DONE;
                end
            end
            default:
                ;
        endcase
        res.count = shadow_count[COUNT_OUT_W-1:0];
        return res;
    endfunction

    // Script rows: a request with a typed response, a request left to the
    // shadow set, and a limit write.
    function automatic script_row_t act_row(input logic [2:0] a, input logic [31:0] e,
                                            input logic [1:0] st, input logic [31:0] v,
                                            input logic [6:0] c);
        script_row_t r;
        r.is_cfg       = 1'b0;
        r.cfg_value    = '0;
        r.item.action  = a;
        r.item.element = e;
        r.typed        = 1'b1;
        r.want.status  = st;
        r.want.value   = v;
        r.want.count   = c;
        return r;
    endfunction

    function automatic script_row_t chk_row(input logic [2:0] a, input logic [31:0] e);
        script_row_t r;
        r       = act_row(a, e, STAT_NONE, '0, '0);
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic script_row_t limit_row(input logic [CFG_W-1:0] v);
        script_row_t r;
        r           = chk_row(ACT_MEMBER, '0);
        r.is_cfg    = 1'b1;
        r.cfg_value = v;
        return r;
    endfunction

    // Weighted random request. Most elements come from a small pool so that
    // repeats, hits on remove and full sets actually occur.
    function automatic bist_req_t random_request(input int ins_weight,
                                                 input logic [31:0] salt);
        bist_req_t item;
        int        roll;
        roll = $urandom_range(0, 99);
        if (roll < ins_weight)
            item.action = ACT_INSERT;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)       item.action = ACT_REMOVE;
            else if (roll < 50)  item.action = ACT_MEMBER;
            else if (roll < 62)  item.action = ACT_TAKE_LAST;
            else if (roll < 64)  item.action = ACT_CLEAR;
            else if (roll < 72)  item.action = ACT_ITER_INIT;
            else if (roll < 96)  item.action = ACT_ITER_NEXT;
            else                 item.action = ACT_UNUSED;
        end
        if ($urandom_range(0, 3) == 0)
            item.element = $urandom;
        else
            item.element = salt ^ 32'($urandom_range(0, 95));
        return item;
    endfunction

    // Offers one request, with random idle cycles in front, and records the
    // expected response once the block takes it.
    task automatic offer_request(input bist_req_t item, input bit typed,
                                 input bist_rsp_t want);
        bist_rsp_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
        predicted = predict_set_action(item);
        pending_responses.push_back(typed ? want : predicted);
        sent_count++;
    endtask

    // Lowers the request valid and waits until every response has come back.
    task automatic drain_responses();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the size limit while the block is idle.
    task automatic write_limit(input logic [CFG_W-1:0] limit);
        drain_responses();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do @(posedge clk); while (!cfg_ready);
        shadow_size_limit = limit;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Response readiness: random idling, with an occasional long hold-off.
    initial
    begin : response_side
        int hold_len;
        forever
        begin
            @(negedge clk);
            if (long_hold_cycles != 0)
            begin
                hold_len         = long_hold_cycles;
                long_hold_cycles = 0;
                rsp_ready <= 1'b0;
                repeat (hold_len) @(negedge clk);
            end
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Response checker against the oldest expectation.
    always @(posedge clk)
    begin : response_check
        bist_rsp_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: response with nothing pending, got status %0d value %0h count %0d",
                         $time, rsp.status, rsp.value, rsp.count);
                error_count++;
            end
            else
            begin
                exp_rsp = pending_responses.pop_front();
                checked_count++;
                if (rsp.status !== exp_rsp.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, exp_rsp.status, rsp.status);
                    error_count++;
                end
                if (rsp.value !== exp_rsp.value)
                begin
                    $display("%0t: value mismatch, expected %0h, got %0h",
                             $time, exp_rsp.value, rsp.value);
                    error_count++;
                end
                if (rsp.count !== exp_rsp.count)
                begin
                    $display("%0t: count mismatch, expected %0d, got %0d",
                             $time, exp_rsp.count, rsp.count);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset, opening script, random phases, drain and verdict.
    initial
    begin : stimulus
        script_row_t script [$];
        bist_req_t   item;
        bist_rsp_t   no_rsp;
        logic [31:0] salt;
        int          ins_weight;
        int          i;
        int          sub;
        int          limit_plan [PLAN_LEN];

        no_rsp     = '0;
        limit_plan = '{64, 1, 20, 127, 0, 64, 7, 33, 64, 2, 45, 64};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Opening script: empty set after reset, extremes of the element,
        // repeats, iteration across a removal, unused code, limit below count.
        script.push_back(act_row(ACT_TAKE_LAST, 32'h0,        STAT_NONE,    32'h0, 7'd0));
        script.push_back(act_row(ACT_ITER_NEXT, 32'h0,        STAT_NONE,    32'h0, 7'd0));
        script.push_back(act_row(ACT_MEMBER,    32'h0,        STAT_NONE,    32'h0, 7'd0));
        script.push_back(act_row(ACT_REMOVE,    32'h5,        STAT_NONE,    32'h0, 7'd0));
        script.push_back(act_row(ACT_INSERT,    32'h8000_0000, STAT_DONE,   32'h0, 7'd1));
        script.push_back(act_row(ACT_INSERT,    32'h7fff_ffff, STAT_DONE,   32'h0, 7'd2));
        script.push_back(act_row(ACT_INSERT,    32'h0,        STAT_DONE,    32'h0, 7'd3));
        script.push_back(act_row(ACT_INSERT,    32'hffff_ffff, STAT_DONE,   32'h0, 7'd4));
        script.push_back(act_row(ACT_INSERT,    32'h8000_0000, STAT_PRESENT, 32'h0, 7'd4));
        script.push_back(act_row(ACT_MEMBER,    32'h7fff_ffff, STAT_DONE,   32'h0, 7'd4));
        script.push_back(act_row(ACT_MEMBER,    32'h1,        STAT_NONE,    32'h0, 7'd4));
        script.push_back(act_row(ACT_ITER_INIT, 32'h0,        STAT_DONE,    32'h0, 7'd4));
        script.push_back(act_row(ACT_ITER_NEXT, 32'h0, STAT_DONE, 32'h8000_0000, 7'd4));
        script.push_back(act_row(ACT_ITER_NEXT, 32'h0, STAT_DONE, 32'h7fff_ffff, 7'd4));
        script.push_back(act_row(ACT_REMOVE,    32'h7fff_ffff, STAT_DONE,   32'h0, 7'd3));
        script.push_back(chk_row(ACT_ITER_NEXT, 32'h0));
        script.push_back(chk_row(ACT_ITER_NEXT, 32'h0));
        script.push_back(act_row(ACT_TAKE_LAST, 32'h0, STAT_DONE, 32'hffff_ffff, 7'd2));
        script.push_back(act_row(ACT_UNUSED,    32'hffff_ffff, STAT_NONE,   32'h0, 7'd2));
        script.push_back(act_row(ACT_CLEAR,     32'h0,        STAT_DONE,    32'h0, 7'd0));
        script.push_back(act_row(ACT_ITER_NEXT, 32'h0,        STAT_NONE,    32'h0, 7'd0));
        script.push_back(chk_row(ACT_INSERT,    32'd10));
        script.push_back(chk_row(ACT_INSERT,    32'd11));
        script.push_back(limit_row(7'd1));
        script.push_back(act_row(ACT_INSERT,    32'd12,       STAT_FULL,    32'h0, 7'd2));
        script.push_back(act_row(ACT_INSERT,    32'd10,       STAT_FULL,    32'h0, 7'd2));
        script.push_back(limit_row(7'd0));
        script.push_back(chk_row(ACT_TAKE_LAST, 32'h0));
        script.push_back(act_row(ACT_INSERT,    32'd5,        STAT_FULL,    32'h0, 7'd1));

        send_idle_pct = 24;
        recv_idle_pct = 54;
        foreach (script[i])
        begin
            if (script[i].is_cfg)
                write_limit(script[i].cfg_value);
            else
                offer_request(script[i].item, script[i].typed, script[i].want);
        end

        // Random phases: four limits per idling pattern.
        for (sub = 0; sub < PLAN_LEN; sub++)
        begin
            write_limit(limit_plan[sub][CFG_W-1:0]);
            case (sub / 4)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct = 54;
                end
                1:
                begin
                    send_idle_pct = 54;
                    recv_idle_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // Hold the response side off long enough for the input to stall.
            if (sub == 8)
                long_hold_cycles = LONG_HOLD;
            salt       = $urandom;
            ins_weight = $urandom_range(30, 70);
            for (i = 0; i < ITEMS_PER_LIMIT; i++)
            begin
                item = random_request(ins_weight, salt);
                offer_request(item, 1'b0, no_rsp);
            end
        end

        drain_responses();
        $display("Sent %0d requests across %0d size limits; %0d responses compared.",
                 sent_count, PLAN_LEN + 3, checked_count);
        $display("Mismatches found: %0d.", error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== bounded_integer_set_table_core.f =====
+incdir+design
design/bist_pkg.sv
design/bist_cell.sv
design/bounded_integer_set_table_core.sv
design/bist_checker.sv
test/tb.sv
